[hdl/hav_pkg.sv]
// hav_pkg: shared widths, angle constants and elaboration-time tables
// (cordic arctangent table, cordic gain, degree-to-radian factor).
// no dependencies
`timescale 1ns / 1ps

package hav_pkg;

  localparam int unsigned LAT_W    = 28;
  localparam int unsigned LON_W    = 29;
  localparam int unsigned RADIUS_W = 23;
  localparam int unsigned DIST_W   = 25;
  localparam int unsigned ANG_W    = 30;
  localparam int unsigned MAG_W    = 28;
  localparam int unsigned Q_W      = 34;
  localparam int unsigned P_W      = 2 * Q_W;
  localparam int unsigned H_W      = 33;
  localparam int unsigned SQ_IN_W  = 63;
  localparam int unsigned SQ_W     = 32;
  localparam int unsigned RAD_LO_W = 18;
  localparam int unsigned RAD_W    = 36;

  localparam logic signed [31:0] UDEG2_FULL    = 32'sd720000000;
  localparam logic signed [31:0] UDEG2_HALF    = 32'sd360000000;
  localparam logic signed [31:0] UDEG2_QUARTER = 32'sd180000000;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 23'd6378137;
  localparam logic [DIST_W-1:0]   DIST_MAX   = 25'd25132742;
  localparam logic [H_W-1:0]      H_ONE      = 33'h1_0000_0000;

  function automatic logic [63:0] round_shr(input logic [63:0] v, input int unsigned s);
    logic [63:0] r;
    if (s == 0) r = v;
    else r = (v + (64'd1 << (s - 1))) >> s;
    return r;
  endfunction

  // shift-subtract quotient, used only while building the tables
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // pi in Q60 from 4 atan(1/5) - atan(1/239)
  function automatic logic [63:0] pi_q60();
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] s5;
    logic [63:0] s239;
    int unsigned k;
    p = udiv64(64'd1 << 62, 64'd5);
    s5 = '0;
    k = 0;
    while (p != 0) begin
      t = udiv64(p, 64'(2 * k + 1));
      if (k[0]) s5 = s5 - t;
      else s5 = s5 + t;
      p = udiv64(p, 64'd25);
      k++;
    end
    p = udiv64(64'd1 << 62, 64'd239);
    s239 = '0;
    k = 0;
    while (p != 0) begin
      t = udiv64(p, 64'(2 * k + 1));
      if (k[0]) s239 = s239 - t;
      else s239 = s239 + t;
      p = udiv64(p, 64'd57121);
      k++;
    end
    return (s5 << 2) - s239;
  endfunction

  function automatic logic [63:0] atan_pow2_q62(input int unsigned i);
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] s;
    int unsigned k;
    p = 64'd1 << (62 - i);
    s = '0;
    k = 0;
    while (p != 0) begin
      t = udiv64(p, 64'(2 * k + 1));
      if (k[0]) s = s - t;
      else s = s + t;
      p = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
      k++;
    end
    return s;
  endfunction

  function automatic logic [63:0] atan_entry(input int unsigned i, input int unsigned f);
    logic [63:0] v;
    v = (i == 0) ? pi_q60() : atan_pow2_q62(i);
    return round_shr(v, 62 - f);
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] a);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v = a;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] cordic_gain(input int unsigned f, input int unsigned n);
    logic [63:0] k2;
    logic [63:0] k31;
    logic [63:0] r;
    k2 = 64'd1 << 62;
    for (int unsigned i = 0; i < n; i++) begin
      if (2 * i < 62) k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    k31 = isqrt64(k2);
    if (f >= 31) r = k31 << (f - 31);
    else r = round_shr(k31, 31 - f);
    return r;
  endfunction

  function automatic logic [63:0] rad_per_unit_q62();
    return udiv64(pi_q60(), 64'd90000000);
  endfunction

endpackage

[hdl/hav_sincos.sv]
// hav_sincos: angle folding, radian conversion and pipelined rotation cordic,
// one stage per iteration; returns sine or cosine in Q1.31.
// depends on hav_pkg
`timescale 1ns / 1ps

module hav_sincos #(
  parameter int unsigned ANGLE_FRAC_BITS = 30,
  parameter int unsigned CORDIC_STAGES   = 32,
  parameter bit          COS_OUT         = 1'b0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [hav_pkg::ANG_W-1:0]   angle_i,
  output logic                               valid_o,
  output logic signed [hav_pkg::Q_W-1:0]     value_o
);
  import hav_pkg::*;

  localparam int unsigned F   = ANGLE_FRAC_BITS;
  localparam int unsigned N   = CORDIC_STAGES;
  localparam int unsigned W   = F + 3;
  localparam int unsigned SHR = 62 - F;
  localparam logic [63:0] RAD = rad_per_unit_q62();
  localparam logic [RAD_LO_W-1:0] RAD_LO = RAD[RAD_LO_W-1:0];
  localparam logic [RAD_W-RAD_LO_W-1:0] RAD_HI = RAD[RAD_W-1:RAD_LO_W];
  localparam logic [47:0] RND = 48'(64'd1 << (SHR - 1));
  localparam logic signed [W-1:0] KX = W'(cordic_gain(F, N));

  logic signed [31:0] a_ext;
  logic signed [31:0] wrap_d, wrap_q;
  logic signed [31:0] fold;
  logic               cneg_d, cneg2_q, cneg3_q;
  logic               neg_d, neg3_q;
  logic [MAG_W-1:0]   mag_d, mag_q;
  logic               neg2_q;
  logic [47:0]        p_lo_q;
  logic [RAD_W-RAD_LO_W+MAG_W-1:0] p_hi_q;
  logic [63:0]        psum;
  logic [F:0]         zmag;
  logic signed [W-1:0] z_init;
  logic               v1_q, v2_q, v3_q;

  logic signed [W-1:0] x_q [N+1];
  logic signed [W-1:0] y_q [N+1];
  logic signed [W-1:0] z_q [N+1];
  logic                cn_q [N+1];
  logic                cv_q [N+1];

  assign a_ext = 32'(angle_i);

  always_comb begin
    if (a_ext >= UDEG2_HALF) wrap_d = a_ext - UDEG2_FULL;
    else if (a_ext < -UDEG2_HALF) wrap_d = a_ext + UDEG2_FULL;
    else wrap_d = a_ext;
  end

  always_comb begin
    cneg_d = 1'b0;
    fold   = wrap_q;
    if (wrap_q > UDEG2_QUARTER) begin
      fold   = UDEG2_HALF - wrap_q;
      cneg_d = 1'b1;
    end else if (wrap_q < -UDEG2_QUARTER) begin
      fold   = -UDEG2_HALF - wrap_q;
      cneg_d = 1'b1;
    end
    neg_d = fold[31];
    mag_d = neg_d ? MAG_W'(-fold) : MAG_W'(fold);
  end

  assign psum   = (64'(p_hi_q) << RAD_LO_W) + 64'(p_lo_q);
  assign zmag   = psum[SHR +: F + 1];
  assign z_init = neg3_q ? -$signed(W'(zmag)) : $signed(W'(zmag));

  always_ff @(posedge clk_i) begin
    wrap_q  <= wrap_d;
    mag_q   <= mag_d;
    neg2_q  <= neg_d;
    cneg2_q <= cneg_d;
    p_lo_q  <= 48'(mag_q) * 48'(RAD_LO) + RND;
    p_hi_q  <= (RAD_W-RAD_LO_W+MAG_W)'(mag_q) * (RAD_W-RAD_LO_W+MAG_W)'(RAD_HI);
    neg3_q  <= neg2_q;
    cneg3_q <= cneg2_q;
    x_q[0]  <= KX;
    y_q[0]  <= '0;
    z_q[0]  <= z_init;
    cn_q[0] <= cneg3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      cv_q[0] <= 1'b0;
    end else begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      cv_q[0] <= v3_q;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [W-1:0] AT = W'(atan_entry(i, F));
    logic signed [W-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (!z_q[i][W-1]) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - AT;
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + AT;
      end
      cn_q[i+1] <= cn_q[i];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else begin
        cv_q[i+1] <= cv_q[i];
      end
    end
  end

  logic signed [W-1:0]   vsel;
  logic                  oneg;
  logic [W-1:0]          omag;
  logic [Q_W-1:0]        qmag;
  logic signed [Q_W-1:0] value_d, value_q;
  logic                  out_v_q;

  always_comb begin
    if (COS_OUT) vsel = cn_q[N] ? -x_q[N] : x_q[N];
    else vsel = y_q[N];
    oneg = vsel[W-1];
    omag = oneg ? W'(-vsel) : W'(vsel);
  end

  if (F > 31) begin : g_round
    logic [W:0] rsum;
    assign rsum = {1'b0, omag} + ((W+1)'(1) << (F - 32));
    assign qmag = Q_W'(rsum >> (F - 31));
  end else if (F == 31) begin : g_same
    assign qmag = Q_W'(omag);
  end else begin : g_widen
    assign qmag = Q_W'(omag) << (31 - F);
  end

  assign value_d = oneg ? -$signed(qmag) : $signed(qmag);

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= cv_q[N];
    end
  end

  assign valid_o = out_v_q;
  assign value_o = value_q;

endmodule

[hdl/hav_isqrt.sv]
// hav_isqrt: pipelined restoring integer square root (floor), one root bit
// per stage. depends on hav_pkg
`timescale 1ns / 1ps

module hav_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [hav_pkg::SQ_IN_W-1:0]   radicand_i,
  output logic                          valid_o,
  output logic [hav_pkg::SQ_W-1:0]      root_o
);
  import hav_pkg::*;

  logic [SQ_IN_W-1:0] rem_q  [SQ_W];
  logic [SQ_W-1:0]    root_q [SQ_W];
  logic               v_q    [SQ_W];

  for (genvar k = 0; k < SQ_W; k++) begin : g_step
    localparam int unsigned B = SQ_W - 1 - k;
    logic [SQ_IN_W-1:0] rem_in;
    logic [SQ_W-1:0]    root_in;
    logic               v_in;
    logic [63:0]        trial;

    if (k == 0) begin : g_first
      assign rem_in  = radicand_i;
      assign root_in = '0;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign trial = (64'(root_in) << (B + 1)) + (64'd1 << (2 * B));

    always_ff @(posedge clk_i) begin
      if ({1'b0, rem_in} >= trial) begin
        rem_q[k]  <= rem_in - trial[SQ_IN_W-1:0];
        root_q[k] <= root_in | (SQ_W'(1) << B);
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end
  end

  assign valid_o = v_q[SQ_W-1];
  assign root_o  = root_q[SQ_W-1];

endmodule

[hdl/hav_atan.sv]
// hav_atan: pipelined vectoring cordic, angle of (x, y) clamped at zero.
// depends on hav_pkg
`timescale 1ns / 1ps

module hav_atan #(
  parameter int unsigned ANGLE_FRAC_BITS = 30,
  parameter int unsigned CORDIC_STAGES   = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [hav_pkg::SQ_W-1:0]   x_i,
  input  logic [hav_pkg::SQ_W-1:0]   y_i,
  output logic                       valid_o,
  output logic [ANGLE_FRAC_BITS:0]   angle_o
);
  import hav_pkg::*;

  localparam int unsigned F  = ANGLE_FRAC_BITS;
  localparam int unsigned N  = CORDIC_STAGES;
  localparam int unsigned XW = SQ_W + 3;
  localparam int unsigned ZW = F + 3;

  logic signed [XW-1:0] x_q [N];
  logic signed [XW-1:0] y_q [N];
  logic signed [ZW-1:0] z_q [N];
  logic                 v_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [ZW-1:0] AT = ZW'(atan_entry(i, F));
    logic signed [XW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in;
    logic                 v_in;

    if (i == 0) begin : g_first
      assign x_in = $signed(XW'(x_i));
      assign y_in = $signed(XW'(y_i));
      assign z_in = '0;
      assign v_in = valid_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign v_in = v_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk_i) begin
      if (!y_in[XW-1]) begin
        x_q[i] <= x_in + dx;
        y_q[i] <= y_in - dy;
        z_q[i] <= z_in + AT;
      end else begin
        x_q[i] <= x_in - dx;
        y_q[i] <= y_in + dy;
        z_q[i] <= z_in - AT;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end
  end

  logic [F:0] angle_d, angle_q;
  logic       out_v_q;

  assign angle_d = z_q[N-1][ZW-1] ? '0 : z_q[N-1][F:0];

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= v_q[N-1];
    end
  end

  assign valid_o = out_v_q;
  assign angle_o = angle_q;

endmodule

[hdl/haversine_distance.sv]
// haversine_distance: great-circle distance of two points, fully pipelined.
// depends on hav_pkg, hav_sincos, hav_isqrt, hav_atan
//
// usage
//   request: lat_a_i, lon_a_i, lat_b_i, lon_b_i in signed microdegrees, taken
//   at a rising edge with start high and busy low. busy is always low, so a
//   request can be issued on every cycle.
//   result: distance_m_o in whole meters is valid for exactly one cycle while
//   done_o is high; results leave in request order, one per request.
//   path: results pass through the two cordic pipelines and the 32-stage
//   square root.
//   throughput: one request per cycle.
//   radius: cfg_data_i is written when cfg_valid_i and cfg_ready_o are high;
//   cfg_ready_o is always high. write it only with no request in flight.
//   reset: rst_ni clears all valid bits and loads the radius 6378137 m; no
//   clearing pass, requests are taken from the first cycle after reset.
//   the receiver has no back pressure; done_o is never held.
`timescale 1ns / 1ps

module haversine_distance #(
  parameter int unsigned ANGLE_FRAC_BITS = 30,
  parameter int unsigned CORDIC_STAGES   = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [hav_pkg::LAT_W-1:0]   lat_a_i,
  input  logic signed [hav_pkg::LON_W-1:0]   lon_a_i,
  input  logic signed [hav_pkg::LAT_W-1:0]   lat_b_i,
  input  logic signed [hav_pkg::LON_W-1:0]   lon_b_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hav_pkg::RADIUS_W-1:0]       cfg_data_i,
  output logic                               done_o,
  output logic [hav_pkg::DIST_W-1:0]         distance_m_o
);
  import hav_pkg::*;

  localparam int unsigned F      = ANGLE_FRAC_BITS;
  localparam int unsigned TERM_W = 36;
  localparam int unsigned SUM_W  = 38;
  localparam int unsigned PF_W   = RADIUS_W + F;

  logic [RADIUS_W-1:0] radius_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= cfg_data_i;
    end
  end

  // input stage: angle differences and doubled latitudes
  logic signed [ANG_W-1:0] dlat_q, dlon_q, la2_q, lb2_q;
  logic                    in_v_q;

  always_ff @(posedge clk_i) begin
    dlat_q <= ANG_W'(lat_a_i) - ANG_W'(lat_b_i);
    dlon_q <= ANG_W'(lon_a_i) - ANG_W'(lon_b_i);
    la2_q  <= ANG_W'(lat_a_i) <<< 1;
    lb2_q  <= ANG_W'(lat_b_i) <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start && !busy;
    end
  end

  logic signed [Q_W-1:0] s1, s2, c1, c2;
  logic                  s1_v, s2_v, c1_v, c2_v, sc_v;

  hav_sincos #(.ANGLE_FRAC_BITS(F), .CORDIC_STAGES(CORDIC_STAGES), .COS_OUT(1'b0)) u_sin_lat (
    .clk_i, .rst_ni, .valid_i(in_v_q), .angle_i(dlat_q), .valid_o(s1_v), .value_o(s1)
  );
  hav_sincos #(.ANGLE_FRAC_BITS(F), .CORDIC_STAGES(CORDIC_STAGES), .COS_OUT(1'b0)) u_sin_lon (
    .clk_i, .rst_ni, .valid_i(in_v_q), .angle_i(dlon_q), .valid_o(s2_v), .value_o(s2)
  );
  hav_sincos #(.ANGLE_FRAC_BITS(F), .CORDIC_STAGES(CORDIC_STAGES), .COS_OUT(1'b1)) u_cos_a (
    .clk_i, .rst_ni, .valid_i(in_v_q), .angle_i(la2_q), .valid_o(c1_v), .value_o(c1)
  );
  hav_sincos #(.ANGLE_FRAC_BITS(F), .CORDIC_STAGES(CORDIC_STAGES), .COS_OUT(1'b1)) u_cos_b (
    .clk_i, .rst_ni, .valid_i(in_v_q), .angle_i(lb2_q), .valid_o(c2_v), .value_o(c2)
  );

  assign sc_v = s1_v & s2_v & c1_v & c2_v;

  // haversine assembly
  logic [P_W-1:0]          sq1_q, sq2_q;
  logic signed [P_W-1:0]   cc_q;
  logic [H_W:0]            h1_d, h1_q, h1b_q, h1c_q;
  logic [Q_W-1:0]          cq_d, cq_q;
  logic signed [Q_W-1:0]   bq_d, bq_q;
  logic                    ccneg;
  logic [P_W-1:0]          ccm;
  logic [Q_W-1:0]          bqm;
  logic signed [P_W-1:0]   bc_q;
  logic                    bcneg;
  logic [P_W-1:0]          bcm;
  logic [TERM_W-1:0]       tm;
  logic signed [TERM_W-1:0] term_d, term_q;
  logic signed [SUM_W-1:0] hs;
  logic [H_W-1:0]          hq_d, hq_q;
  logic [SQ_IN_W-1:0]      ary_q, arx_q;
  logic [5:0]              mv_q;

  always_comb begin
    h1_d  = (H_W+1)'((sq1_q + (P_W'(1) << 29)) >> 30);
    cq_d  = Q_W'((sq2_q + (P_W'(1) << 30)) >> 31);
    ccneg = cc_q[P_W-1];
    ccm   = ccneg ? P_W'(-cc_q) : P_W'(cc_q);
    bqm   = Q_W'((ccm + (P_W'(1) << 30)) >> 31);
    bq_d  = ccneg ? -$signed(bqm) : $signed(bqm);
  end

  always_comb begin
    bcneg  = bc_q[P_W-1];
    bcm    = bcneg ? P_W'(-bc_q) : P_W'(bc_q);
    tm     = TERM_W'((bcm + (P_W'(1) << 29)) >> 30);
    term_d = bcneg ? -$signed(tm) : $signed(tm);
  end

  always_comb begin
    hs = $signed(SUM_W'(h1c_q)) + SUM_W'(term_q);
    if (hs[SUM_W-1]) hq_d = '0;
    else if (hs > $signed(SUM_W'(H_ONE))) hq_d = H_ONE;
    else hq_d = H_W'(hs);
  end

  always_ff @(posedge clk_i) begin
    sq1_q  <= $unsigned(P_W'(s1) * P_W'(s1));
    sq2_q  <= $unsigned(P_W'(s2) * P_W'(s2));
    cc_q   <= P_W'(c1) * P_W'(c2);
    h1_q   <= h1_d;
    cq_q   <= cq_d;
    bq_q   <= bq_d;
    bc_q   <= P_W'(bq_q) * P_W'($signed({1'b0, cq_q}));
    h1b_q  <= h1_q;
    term_q <= term_d;
    h1c_q  <= h1b_q;
    hq_q   <= hq_d;
    ary_q  <= SQ_IN_W'(hq_q) << 30;
    arx_q  <= SQ_IN_W'(H_ONE - hq_q) << 30;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= '0;
    end else begin
      mv_q <= {mv_q[4:0], sc_v};
    end
  end

  // square roots and angle
  logic [SQ_W-1:0] root_y, root_x;
  logic            ry_v, rx_v, sq_v;

  hav_isqrt u_sqrt_h (
    .clk_i, .rst_ni, .valid_i(mv_q[5]), .radicand_i(ary_q), .valid_o(ry_v), .root_o(root_y)
  );
  hav_isqrt u_sqrt_1mh (
    .clk_i, .rst_ni, .valid_i(mv_q[5]), .radicand_i(arx_q), .valid_o(rx_v), .root_o(root_x)
  );

  assign sq_v = ry_v & rx_v;

  logic [F:0] ang;
  logic       ang_v;

  hav_atan #(.ANGLE_FRAC_BITS(F), .CORDIC_STAGES(CORDIC_STAGES)) u_atan (
    .clk_i, .rst_ni, .valid_i(sq_v), .x_i(root_x), .y_i(root_y),
    .valid_o(ang_v), .angle_o(ang)
  );

  // distance = r * 2 * angle
  logic [F-1:0]        frac;
  logic [1:0]          ipart;
  logic [PF_W-1:0]     pf_q;
  logic [DIST_W-1:0]   pi_q;
  logic [DIST_W:0]     dsum;
  logic [DIST_W-1:0]   dist_d, dist_q;
  logic                d1_v_q, done_q;

  assign frac  = {ang[F-2:0], 1'b0};
  assign ipart = ang[F:F-1];

  assign dsum   = (DIST_W+1)'(pi_q) + (DIST_W+1)'(pf_q >> F);
  assign dist_d = (dsum > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX : dsum[DIST_W-1:0];

  always_ff @(posedge clk_i) begin
    pf_q   <= PF_W'(radius_q) * PF_W'(frac);
    pi_q   <= DIST_W'(radius_q) * DIST_W'(ipart);
    dist_q <= dist_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      d1_v_q <= ang_v;
      done_q <= d1_v_q;
    end
  end

  assign done_o       = done_q;
  assign distance_m_o = dist_q;

  // haversine stays within [0, 1]
  a_hq_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_q[4] |-> hq_q <= H_ONE)
    else $error("haversine out of range");

  // floor roots of h and 1-h cannot exceed the unit circle
  a_root_norm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v |-> (64'(root_y) * 64'(root_y) + 64'(root_x) * 64'(root_x)) <= (64'd1 << 62))
    else $error("square roots exceed unit norm");

  // saturated distance
  a_dist_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> distance_m_o <= DIST_MAX)
    else $error("distance above maximum");

endmodule
